[hw/rtl/bpq_pkg.sv]
// Shared types and constants for the block power-of-two quantizer.
package bpq_pkg;

   // Shared exponent: width and clamp value
   localparam int SCALE_W   = 4;
   localparam int SCALE_MAX = 15;

   typedef logic [SCALE_W-1:0] scale_type;

endpackage

[hw/rtl/bpq_if.sv]
// Valid/ready channel interfaces for the quantizer request and response sides.
interface bpq_req_if #(
   parameter int LANES     = 8,
   parameter int ACT_WIDTH = 27
);
   logic                                valid;
   logic                                ready;
   logic [LANES-1:0][ACT_WIDTH-1:0]     act_lane;
   logic                                end_of_layer;

   modport source (output valid, output act_lane, output end_of_layer, input ready);
   modport sink   (input valid, input act_lane, input end_of_layer, output ready);
endinterface

interface bpq_rsp_if import bpq_pkg::*; #(
   parameter int LANES      = 8,
   parameter int QUANT_BITS = 8
);
   logic                                valid;
   logic                                ready;
   logic [LANES-1:0][QUANT_BITS-1:0]    quant_lane;
   scale_type                           block_scale;
   logic                                last_out;

   modport source (output valid, output quant_lane, output block_scale, output last_out,
                   input ready);
   modport sink   (input valid, input quant_lane, input block_scale, input last_out,
                   output ready);
endinterface

[hw/rtl/bpq_peak.sv]
// Group exponent: ceil(log2(max |x|)) - (QUANT_BITS-1), clamped to 0..SCALE_MAX.
module bpq_peak import bpq_pkg::*; #(
   parameter int LANES      = 8,
   parameter int ACT_WIDTH  = 27,
   parameter int QUANT_BITS = 8
) (
   input  logic [LANES-1:0][ACT_WIDTH-1:0] act_lane,
   output scale_type                       block_scale
);

   localparam int DW = ACT_WIDTH - 1;

   logic [LANES-1:0][DW-1:0] mag_m1;
   logic [DW-1:0]            mag_or;
   logic [SCALE_MAX-1:0]     therm;

   // |x| - 1 per lane, floored at zero; for negative x this is just ~x
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (act_lane[i][ACT_WIDTH-1]) begin
            mag_m1[i] = ~act_lane[i][DW-1:0];
         end else if (act_lane[i] == '0) begin
            mag_m1[i] = '0;
         end else begin
            mag_m1[i] = act_lane[i][DW-1:0] - 1'b1;
         end
      end
   end

   // OR of all lanes has the same bit length as the largest one
   always_comb begin
      mag_or = '0;
      for (int i = 0; i < LANES; i++) begin
         mag_or = mag_or | mag_m1[i];
      end
   end

   // scale >= k exactly when max|x| - 1 has a bit at or above k + QUANT_BITS - 2
   always_comb begin
      for (int k = 1; k <= SCALE_MAX; k++) begin
         therm[k-1] = |(mag_or >> (k + QUANT_BITS - 2));
      end
   end

   // thermometer is monotone: highest set position wins
   always_comb begin
      block_scale = '0;
      for (int k = 1; k <= SCALE_MAX; k++) begin
         if (therm[k-1]) begin
            block_scale = SCALE_W'(k);
         end
      end
   end

endmodule

[hw/rtl/bpq_lane.sv]
// One lane: arithmetic shift right with round-half-up, then signed saturation.
module bpq_lane import bpq_pkg::*; #(
   parameter int ACT_WIDTH  = 27,
   parameter int QUANT_BITS = 8
) (
   input  logic [ACT_WIDTH-1:0]  act,
   input  scale_type             scale,
   output logic [QUANT_BITS-1:0] quant
);

   localparam int XW = ACT_WIDTH + 1;
   localparam int SW = ((XW > QUANT_BITS) ? XW : QUANT_BITS) + 1;
   localparam logic signed [SW-1:0] QMAX = SW'((1 << (QUANT_BITS - 1)) - 1);
   localparam logic signed [SW-1:0] QMIN = SW'(-(1 << (QUANT_BITS - 1)));

   logic signed [XW-1:0] rnd;
   logic signed [XW-1:0] sum;
   logic signed [XW-1:0] shifted;
   logic signed [SW-1:0] wide;

   // half an output step added before the shift
   always_comb begin
      if (scale == '0) begin
         rnd = '0;
      end else begin
         rnd = XW'(1) << (scale - 1'b1);
      end
   end

   assign sum     = $signed({act[ACT_WIDTH-1], act}) + rnd;
   assign shifted = sum >>> scale;
   assign wide    = $signed({{(SW - XW){shifted[XW-1]}}, shifted});

   // clamp into the signed output range
   always_comb begin
      if (wide > QMAX) begin
         quant = QMAX[QUANT_BITS-1:0];
      end else if (wide < QMIN) begin
         quant = QMIN[QUANT_BITS-1:0];
      end else begin
         quant = wide[QUANT_BITS-1:0];
      end
   end

endmodule

[hw/rtl/block_pow2_dynamic_quantizer_unit.sv]
// Top level of the block power-of-two quantizer: input register, single pass, output register.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------------------
//   req_ch   | in  | valid/ready        | act_lane[LANES], end_of_layer
//   rsp_ch   | out | valid/ready        | quant_lane[LANES], block_scale, last_out
//
// One vector per cycle unless rsp_ch stalls. A request transfer loads the input register;
// the exponent search and the per-lane shift/round/saturate run combinationally into the
// output register, from which the response is driven.
// Each register loads when it is empty or the one after it moves; with a response
// held and one vector waiting, req_ch.ready drops until the response transfers.
// Synchronous reset clears the stage valid bits only.
module block_pow2_dynamic_quantizer_unit import bpq_pkg::*; #(
   parameter int LANES      = 8,
   parameter int ACT_WIDTH  = 27,
   parameter int QUANT_BITS = 8
) (
   input  logic          clock,
   input  logic          reset,
   bpq_req_if.sink       req_ch,
   bpq_rsp_if.source     rsp_ch
);

   // stage valids and enables
   logic v_a_ff, v_a_in;
   logic v_c_ff, v_c_in;
   logic en_a, en_c;

   // stage payloads
   logic [LANES-1:0][ACT_WIDTH-1:0]  act_a_ff;
   logic                             last_a_ff;
   logic [LANES-1:0][QUANT_BITS-1:0] quant_c_ff;
   logic [LANES-1:0][QUANT_BITS-1:0] quant_c_in;
   scale_type                        scale_c_ff;
   scale_type                        scale_c_in;
   logic                             last_c_ff;

   // flow control: a stage moves when empty or when the next one moves
   assign en_c = !v_c_ff || rsp_ch.ready;
   assign en_a = !v_a_ff || en_c;

   assign v_a_in = en_a ? req_ch.valid : v_a_ff;
   assign v_c_in = en_c ? v_a_ff : v_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_c_ff <= 1'b0;
      end else begin
         v_a_ff <= v_a_in;
         v_c_ff <= v_c_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (en_a) begin
         act_a_ff  <= req_ch.act_lane;
         last_a_ff <= req_ch.end_of_layer;
      end
   end

   // exponent search
   bpq_peak #(
      .LANES      (LANES),
      .ACT_WIDTH  (ACT_WIDTH),
      .QUANT_BITS (QUANT_BITS)
   ) u_peak (
      .act_lane    (act_a_ff),
      .block_scale (scale_c_in)
   );

   // per-lane quantizers
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      bpq_lane #(
         .ACT_WIDTH  (ACT_WIDTH),
         .QUANT_BITS (QUANT_BITS)
      ) u_lane (
         .act   (act_a_ff[g]),
         .scale (scale_c_in),
         .quant (quant_c_in[g])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (en_c) begin
         quant_c_ff <= quant_c_in;
         scale_c_ff <= scale_c_in;
         last_c_ff  <= last_a_ff;
      end
   end

   assign req_ch.ready       = en_a;
   assign rsp_ch.valid       = v_c_ff;
   assign rsp_ch.quant_lane  = quant_c_ff;
   assign rsp_ch.block_scale = scale_c_ff;
   assign rsp_ch.last_out    = last_c_ff;

   // an empty output stage must never block the request side
   a_ready_when_empty: assert property (@(posedge clock) !v_c_ff |-> req_ch.ready)
      else $error("request not ready while output stage is empty");

   // exponent and last flag move from the input stage to the output unchanged
   a_in_to_out: assert property (@(posedge clock) disable iff (reset)
      (v_a_ff && en_c) |=> (rsp_ch.block_scale == $past(scale_c_in)) &&
                           (rsp_ch.last_out == $past(last_a_ff)) && rsp_ch.valid)
      else $error("input stage transfer lost or corrupted");

   // reset empties every stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid && !v_a_ff)
      else $error("pipeline not empty after reset");

endmodule

[tb/sv/quant_checker.sv]
// Checker for the block quantizer: predicts each response and compares it on transfer.
`timescale 1ns / 1ps

module quant_checker import bpq_pkg::*; #(
   parameter int LANES      = 8,
   parameter int ACT_WIDTH  = 27,
   parameter int QUANT_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   bpq_req_if   req_mon,
   bpq_rsp_if   rsp_mon,
   output int   error_count,
   output int   pending_count,
   output int   checked_count,
   output logic [SCALE_MAX:0] scales_seen
);

   typedef struct {
      logic [LANES-1:0][QUANT_BITS-1:0] quant_lane;
      scale_type                        block_scale;
      logic                             last_out;
   } quant_group_type;

   quant_group_type quant_expected_q[$];

   // Shared exponent from the peak magnitude, then shift/round/saturate per lane
   function automatic quant_group_type quantize_group(
      input logic [LANES-1:0][ACT_WIDTH-1:0] acts,
      input logic                            eol
   );
      quant_group_type         res;
      logic signed [ACT_WIDTH-1:0] raw;
      longint                  lane_val [LANES];
      longint                  mag;
      longint                  peak;
      longint                  q;
      longint                  qmax;
      longint                  qmin;
      int                      k;
      int                      scale;
      qmax = (longint'(1) <<< (QUANT_BITS - 1)) - 1;
      qmin = -(longint'(1) <<< (QUANT_BITS - 1));
      peak = 0;
      for (int i = 0; i < LANES; i++) begin
         raw = acts[i];
         lane_val[i] = raw;
         // full-width magnitude, most negative does not wrap
         mag = (lane_val[i] < 0) ? -lane_val[i] : lane_val[i];
         if (mag > peak) peak = mag;
      end
      // ceiling log2; zero and one both give zero
      k = 0;
      while (k < 63 && (longint'(1) <<< k) < peak) k++;
      scale = k - (QUANT_BITS - 1);
      if (scale < 0) scale = 0;
      if (scale > SCALE_MAX) scale = SCALE_MAX;
      for (int i = 0; i < LANES; i++) begin
         q = lane_val[i];
         if (scale != 0) begin
            // round half up: shift all but one bit, add one, shift the last bit
            q = q >>> (scale - 1);
            q = q + 1;
            q = q >>> 1;
         end
         if (q > qmax) q = qmax;
         if (q < qmin) q = qmin;
         res.quant_lane[i] = q[QUANT_BITS-1:0];
      end
      res.block_scale = scale_type'(scale);
      res.last_out    = eol;
      return res;
   endfunction

   // Response check first, then capture of the new request
   always @(posedge clock) begin
      quant_group_type exp_grp;
      bit              bad;
      if (reset) begin
         error_count   <= 0;
         pending_count <= 0;
         checked_count <= 0;
         scales_seen   <= '0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (quant_expected_q.size() == 0) begin
               $display("%0t: response with no request outstanding: scale %0d last %0b",
                        $time, rsp_mon.block_scale, rsp_mon.last_out);
               error_count <= error_count + 1;
            end else begin
               exp_grp = quant_expected_q.pop_front();
               bad = 1'b0;
               for (int i = 0; i < LANES; i++) begin
                  if (rsp_mon.quant_lane[i] !== exp_grp.quant_lane[i]) begin
                     bad = 1'b1;
                     $display("%0t: quant_lane[%0d] expected %0d actual %0d", $time, i,
                              $signed(exp_grp.quant_lane[i]),
                              $signed(rsp_mon.quant_lane[i]));
                  end
               end
               if (rsp_mon.block_scale !== exp_grp.block_scale) begin
                  bad = 1'b1;
                  $display("%0t: block_scale expected %0d actual %0d", $time,
                           exp_grp.block_scale, rsp_mon.block_scale);
               end
               if (rsp_mon.last_out !== exp_grp.last_out) begin
                  bad = 1'b1;
                  $display("%0t: last_out expected %0b actual %0b", $time,
                           exp_grp.last_out, rsp_mon.last_out);
               end
               if (bad) error_count <= error_count + 1;
               checked_count <= checked_count + 1;
               scales_seen[exp_grp.block_scale] <= 1'b1;
            end
         end
         if (req_mon.valid && req_mon.ready)
            quant_expected_q.push_back(quantize_group(req_mon.act_lane, req_mon.end_of_layer));
         pending_count <= quant_expected_q.size();
      end
   end

endmodule

[tb/sv/tb.sv]
// Top of the quantizer testbench: clock, reset, request and response drivers, verdict.
`timescale 1ns / 1ps

module tb import bpq_pkg::*; ();

   localparam int LANES      = 8;
   localparam int ACT_WIDTH  = 27;
   localparam int QUANT_BITS = 8;
   localparam int RANDOM_GROUPS = 850;

   typedef logic [LANES-1:0][ACT_WIDTH-1:0] act_group_type;

   localparam logic [ACT_WIDTH-1:0] ACT_MAX = {1'b0, {(ACT_WIDTH-1){1'b1}}};
   localparam logic [ACT_WIDTH-1:0] ACT_MIN = {1'b1, {(ACT_WIDTH-1){1'b0}}};

   logic clock;
   logic reset;
   logic burst_on;

   int   errors;
   int   pending;
   int   checked;
   logic [SCALE_MAX:0] scales_seen;
   int   groups_sent;
   int   calm_left;

   bpq_req_if #(.LANES(LANES), .ACT_WIDTH(ACT_WIDTH))   req_ch ();
   bpq_rsp_if #(.LANES(LANES), .QUANT_BITS(QUANT_BITS)) rsp_ch ();

   block_pow2_dynamic_quantizer_unit #(
      .LANES(LANES), .ACT_WIDTH(ACT_WIDTH), .QUANT_BITS(QUANT_BITS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   quant_checker #(
      .LANES(LANES), .ACT_WIDTH(ACT_WIDTH), .QUANT_BITS(QUANT_BITS)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .error_count   (errors),
      .pending_count (pending),
      .checked_count (checked),
      .scales_seen   (scales_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit
   initial begin
      #2ms;
      $display("Timeout with %0d responses outstanding", pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Random value within +/- 2^e
   function automatic logic [ACT_WIDTH-1:0] rand_act(input int e);
      int unsigned span;
      if (e > ACT_WIDTH - 1) e = ACT_WIDTH - 1;
      span = (32'd1 << (e + 1)) - 1;
      return ACT_WIDTH'($urandom_range(span, 0) - (32'd1 << e));
   endfunction

   // Corner values: zero, extremes, +/-1, powers of two and their neighbors
   function automatic logic [ACT_WIDTH-1:0] corner_act();
      int k;
      k = $urandom_range(ACT_WIDTH - 2, 0);
      case ($urandom_range(7, 0))
         0: return '0;
         1: return ACT_MAX;
         2: return ACT_MIN;
         3: return ACT_WIDTH'(1);
         4: return '1;
         5: return ACT_WIDTH'(32'd1 << k);
         6: return ACT_WIDTH'(-(32'sd1 << k));
         default: return ACT_WIDTH'((32'd1 << k) + $urandom_range(1, 0) * 2 - 1);
      endcase
   endfunction

   // Mostly no gap, some short, a few long, with quiet stretches
   function automatic int next_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(99, 0);
      if (r < 3) calm_left = $urandom_range(60, 20);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Offer one group and wait for its transfer
   task automatic send_group(input act_group_type acts, input logic eol, input int gap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.act_lane     <= acts;
      req_ch.end_of_layer <= eol;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      groups_sent++;
   endtask

   function automatic act_group_type fill_group(input logic [ACT_WIDTH-1:0] v);
      act_group_type g;
      for (int i = 0; i < LANES; i++) g[i] = v;
      return g;
   endfunction

   function automatic act_group_type random_group();
      act_group_type g;
      int mode;
      int e;
      mode = $urandom_range(9, 0);
      e = $urandom_range(ACT_WIDTH - 1, 0);
      for (int i = 0; i < LANES; i++) begin
         if (mode == 0)
            g[i] = ACT_WIDTH'($urandom);
         else if (mode == 1 || $urandom_range(15, 0) == 0)
            g[i] = corner_act();
         else
            g[i] = rand_act(e);
      end
      return g;
   endfunction

   // Response side: random stalls, plus a long hold-off when a burst starts
   initial begin
      int  stall_left;
      int  hold_left;
      int  calm_rx;
      logic burst_prev;
      stall_left = 0;
      hold_left  = 0;
      calm_rx    = 0;
      burst_prev = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (burst_on && !burst_prev) hold_left = 80;
         burst_prev = burst_on;
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (calm_rx > 0) begin
               calm_rx--;
            end else begin
               case ($urandom_range(19, 0))
                  0: calm_rx = $urandom_range(60, 20);
                  1, 2, 3, 4: stall_left = $urandom_range(3, 1);
                  5: stall_left = $urandom_range(40, 8);
                  default: ;
               endcase
            end
         end
         @(posedge clock);
      end
   end

   // Request side: directed corners, random groups with a burst, then drain
   initial begin
      act_group_type g;
      groups_sent = 0;
      calm_left   = 0;
      burst_on            <= 1'b0;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.act_lane     <= '0;
      req_ch.end_of_layer <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all zero, magnitude one, values that pass unshifted
      send_group(fill_group('0), 1'b0, next_gap());
      send_group(fill_group(ACT_WIDTH'(1)), 1'b0, next_gap());
      send_group(fill_group('1), 1'b1, next_gap());
      send_group(fill_group(ACT_WIDTH'(127)), 1'b0, next_gap());
      // peak 128 keeps scale zero and saturates; 129 is the first shifted peak
      g = fill_group(ACT_WIDTH'(128));
      g[1] = ACT_WIDTH'(-128);
      send_group(g, 1'b0, next_gap());
      g = fill_group(ACT_WIDTH'(129));
      g[2] = ACT_WIDTH'(-129);
      send_group(g, 1'b0, next_gap());
      // rounding at scale one, odd values of both signs
      g[0] = ACT_WIDTH'(255);  g[1] = ACT_WIDTH'(-255);
      g[2] = ACT_WIDTH'(3);    g[3] = ACT_WIDTH'(-3);
      g[4] = ACT_WIDTH'(1);    g[5] = ACT_WIDTH'(-1);
      g[6] = ACT_WIDTH'(0);    g[7] = ACT_WIDTH'(2);
      send_group(g, 1'b1, next_gap());
      // extremes of the field, clamped exponent
      send_group(fill_group(ACT_MAX), 1'b0, next_gap());
      send_group(fill_group(ACT_MIN), 1'b1, next_gap());
      for (int i = 0; i < LANES; i++) g[i] = (i % 2) ? ACT_MIN : ACT_MAX;
      send_group(g, 1'b0, next_gap());
      // peak exactly at the clamp, and just over it
      g = fill_group(ACT_WIDTH'(32'd1 << 22));
      g[3] = ACT_WIDTH'(12345);
      g[4] = ACT_WIDTH'(-(32'sd1 << 21) - 1);
      send_group(g, 1'b0, next_gap());
      g[0] = ACT_WIDTH'((32'd1 << 22) + 1);
      send_group(g, 1'b1, next_gap());
      // most negative value alone in each lane
      for (int l = 0; l < LANES; l++) begin
         for (int i = 0; i < LANES; i++) g[i] = rand_act(8);
         g[l] = ACT_MIN;
         send_group(g, l[0], next_gap());
      end

      // random groups; a back-to-back burst meets the long receiver hold-off
      for (int n = 0; n < RANDOM_GROUPS; n++) begin
         if (n == 300) burst_on <= 1'b1;
         if (n >= 300 && n < 348) begin
            send_group(random_group(), ($urandom_range(7, 0) == 0), 0);
         end else begin
            if (n == 348) burst_on <= 1'b0;
            send_group(random_group(), ($urandom_range(7, 0) == 0), next_gap());
         end
      end
      req_ch.valid <= 1'b0;

      // drain the pipeline
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d groups, checked %0d responses", groups_sent, checked);
      $display("Scale values reached (bit per scale): %b", scales_seen);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d responses mismatched", errors);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
